/* rtl/core/dct_pkg.sv */
// Shared types, constants and state encoding of the dark channel transmission block.
`default_nettype none
package dct_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int WINDOW    = 15;
  localparam int LINES     = WINDOW + 1;
  localparam int WIN_LO    = WINDOW / 2;
  localparam int WIN_HI    = WINDOW - 1 - WINDOW / 2;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int LINE_W    = $clog2(LINES);
  localparam int MEM_DEPTH = LINES * MAX_WIDTH;

  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_OUTPUT_MODE  = 3'd2;
  localparam logic [2:0] CFG_INVERT_INPUT = 3'd3;
  localparam logic [2:0] CFG_GAIN_CH0     = 3'd4;
  localparam logic [2:0] CFG_GAIN_CH1     = 3'd5;
  localparam logic [2:0] CFG_GAIN_CH2     = 3'd6;
  localparam logic [2:0] CFG_HAZE_KEEP    = 3'd7;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
  } in_item_t;

  typedef struct packed {
    logic signed [16:0] pixel_value;
    logic               frame_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_PREP,
    ST_PIX_WRITE,
    ST_PIX_CMP,
    ST_EM_WRAP,
    ST_EM_BOUNDS,
    ST_EM_READ,
    ST_EM_DRAIN,
    ST_EM_MUL,
    ST_EM_OUT
  } state_e;

  typedef struct packed {
    logic take;
    logic pix_prep;
    logic pix_write;
    logic em_wrap;
    logic em_bounds;
    logic rd_issue;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_func;
    logic input_done;
    logic emit_due;
    logic last_addr;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/dct_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dct_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/dct_ctrl.sv */
// Controller state machine sequencing pixel writes and window-minimum reads.
`default_nettype none
module dct_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire dct_pkg::sts_t sts_i,
  output dct_pkg::cmd_t      cmd_o
);

  dct_pkg::state_e state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != dct_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == dct_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dct_pkg::ST_IDLE: begin
        if (accept) begin
          if (sts_i.in_func == dct_pkg::FUNC_PIXEL) begin
            state_d = dct_pkg::ST_PIX_PREP;
          end else if (sts_i.input_done) begin
            state_d = dct_pkg::ST_EM_WRAP;
          end
        end
      end
      dct_pkg::ST_PIX_PREP:  state_d = dct_pkg::ST_PIX_WRITE;
      dct_pkg::ST_PIX_WRITE: state_d = dct_pkg::ST_PIX_CMP;
      dct_pkg::ST_PIX_CMP: begin
        state_d = sts_i.emit_due ? dct_pkg::ST_EM_WRAP : dct_pkg::ST_IDLE;
      end
      dct_pkg::ST_EM_WRAP:   state_d = dct_pkg::ST_EM_BOUNDS;
      dct_pkg::ST_EM_BOUNDS: state_d = dct_pkg::ST_EM_READ;
      dct_pkg::ST_EM_READ: begin
        if (sts_i.last_addr) begin
          state_d = dct_pkg::ST_EM_DRAIN;
        end
      end
      dct_pkg::ST_EM_DRAIN:  state_d = dct_pkg::ST_EM_MUL;
      dct_pkg::ST_EM_MUL:    state_d = dct_pkg::ST_EM_OUT;
      dct_pkg::ST_EM_OUT: begin
        if (sts_i.out_free) begin
          state_d = dct_pkg::ST_IDLE;
        end
      end
      default: state_d = dct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.take      = accept;
    cmd_o.pix_prep  = (state_q == dct_pkg::ST_PIX_PREP);
    cmd_o.pix_write = (state_q == dct_pkg::ST_PIX_WRITE);
    cmd_o.em_wrap   = (state_q == dct_pkg::ST_EM_WRAP);
    cmd_o.em_bounds = (state_q == dct_pkg::ST_EM_BOUNDS);
    cmd_o.rd_issue  = (state_q == dct_pkg::ST_EM_READ);
    cmd_o.mul       = (state_q == dct_pkg::ST_EM_MUL);
    cmd_o.out_load  = (state_q == dct_pkg::ST_EM_OUT) && sts_i.out_free;
  end

`ifndef SYNTHESIS
  a_read_ends_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dct_pkg::ST_EM_READ && sts_i.last_addr) |=> (state_q == dct_pkg::ST_EM_DRAIN))
    else $error("read sweep did not end in drain");
  a_stall_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dct_pkg::ST_PIX_CMP) |-> in_stall_o)
    else $error("input open while pixel in work");
  a_flush_idle_when_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sts_i.in_func == dct_pkg::FUNC_FLUSH && !sts_i.input_done)
      |=> (state_q == dct_pkg::ST_IDLE))
    else $error("ignored flush started work");
`endif

endmodule
`default_nettype wire

/* rtl/core/dct_datapath.sv */
// Datapath: configuration, position counters, line store, window minimum and output register.
`default_nettype none
module dct_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire dct_pkg::in_item_t in_data_i,
  input  wire logic              out_stall_i,
  output logic                   out_valid_o,
  output dct_pkg::out_item_t     out_data_o,
  input  wire dct_pkg::cmd_t     cmd_i,
  output dct_pkg::sts_t          sts_o
);

  localparam int AddrW = $clog2(dct_pkg::MEM_DEPTH);

  // configuration
  logic [11:0] width_q;
  logic [12:0] height_q;
  logic        mode_q, invert_q;
  logic [15:0] gain_q [3];
  logic [15:0] hkf_q;

  logic [11:0] weff;
  logic [12:0] heff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 12'd640;
      height_q  <= 13'd480;
      mode_q    <= 1'b1;
      invert_q  <= 1'b1;
      gain_q[0] <= 16'd256;
      gain_q[1] <= 16'd256;
      gain_q[2] <= 16'd256;
      hkf_q     <= 16'd62259;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dct_pkg::CFG_IMAGE_WIDTH:  width_q   <= cfg_data_i[11:0];
        dct_pkg::CFG_IMAGE_HEIGHT: height_q  <= cfg_data_i[12:0];
        dct_pkg::CFG_OUTPUT_MODE:  mode_q    <= cfg_data_i[0];
        dct_pkg::CFG_INVERT_INPUT: invert_q  <= cfg_data_i[0];
        dct_pkg::CFG_GAIN_CH0:     gain_q[0] <= cfg_data_i;
        dct_pkg::CFG_GAIN_CH1:     gain_q[1] <= cfg_data_i;
        dct_pkg::CFG_GAIN_CH2:     gain_q[2] <= cfg_data_i;
        dct_pkg::CFG_HAZE_KEEP:    hkf_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      weff = 12'd1;
    end else if (width_q > 12'(dct_pkg::MAX_WIDTH)) begin
      weff = 12'(dct_pkg::MAX_WIDTH);
    end else begin
      weff = width_q;
    end
    heff = (height_q == '0) ? 13'd1 : height_q;
  end

  // item capture and channel scaling
  dct_pkg::in_item_t item_q;
  logic [15:0] p_q [3];
  logic [7:0]  chan [3];
  logic [7:0]  cval [3];
  logic [23:0] prod [3];
  logic [15:0] scaled [3];

  assign chan[0] = item_q.chan0;
  assign chan[1] = item_q.chan1;
  assign chan[2] = item_q.chan2;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cval[k]   = invert_q ? ~chan[k] : chan[k];
      prod[k]   = 24'(cval[k]) * 24'(gain_q[k]);
      if (!mode_q) begin
        scaled[k] = {8'd0, cval[k]};
      end else if (prod[k][23:16] != '0) begin
        scaled[k] = 16'hFFFF;
      end else begin
        scaled[k] = prod[k][15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      item_q <= in_data_i;
    end
    if (cmd_i.pix_prep) begin
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= scaled[k];
      end
    end
  end

  logic [15:0] pix_min;
  always_comb begin
    pix_min = p_q[0];
    if (p_q[1] < pix_min) pix_min = p_q[1];
    if (p_q[2] < pix_min) pix_min = p_q[2];
  end

  // position counters
  logic [11:0] in_col_q, out_col_q;
  logic [12:0] in_row_q, out_row_q;
  logic        done_q;
  logic [11:0] in_col_wrap, out_col_wrap, in_col_inc, out_col_inc;
  logic [12:0] in_row_t, in_row_wrap, out_row_t, out_row_wrap, in_row_inc, out_row_inc;
  logic        fe_next;

  always_comb begin
    in_col_wrap  = (in_col_q >= weff) ? '0 : in_col_q;
    in_row_t     = (in_col_q >= weff) ? in_row_q + 13'd1 : in_row_q;
    in_row_wrap  = (in_row_t >= heff) ? '0 : in_row_t;
    out_col_wrap = (out_col_q >= weff) ? '0 : out_col_q;
    out_row_t    = (out_col_q >= weff) ? out_row_q + 13'd1 : out_row_q;
    out_row_wrap = (out_row_t >= heff) ? '0 : out_row_t;
    in_col_inc   = in_col_q + 12'd1;
    in_row_inc   = in_row_q + 13'd1;
    out_col_inc  = out_col_q + 12'd1;
    out_row_inc  = out_row_q + 13'd1;
    fe_next      = (out_col_inc >= weff) && (out_row_inc >= heff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cmd_i.pix_prep) begin
        in_col_q <= in_col_wrap;
        in_row_q <= in_row_wrap;
        if (done_q) begin
          out_col_q <= '0;
          out_row_q <= '0;
          done_q    <= 1'b0;
        end
      end
      if (cmd_i.pix_write) begin
        if (in_col_inc >= weff) begin
          in_col_q <= '0;
          if (in_row_inc >= heff) begin
            in_row_q <= '0;
            done_q   <= 1'b1;
          end else begin
            in_row_q <= in_row_inc;
          end
        end else begin
          in_col_q <= in_col_inc;
        end
      end
      if (cmd_i.em_wrap) begin
        out_col_q <= out_col_wrap;
        out_row_q <= out_row_wrap;
      end
      if (cmd_i.out_load) begin
        if (out_col_inc >= weff) begin
          out_col_q <= '0;
          if (out_row_inc >= heff) begin
            out_row_q <= '0;
            done_q    <= 1'b0;
          end else begin
            out_row_q <= out_row_inc;
          end
        end else begin
          out_col_q <= out_col_inc;
        end
      end
    end
  end

  // emit decision: output index plus window delay against input index
  logic [24:0] i_q, j_q, dly;
  logic [11:0] wm1;

  assign wm1 = weff - 12'd1;
  assign dly = 25'(dct_pkg::WIN_HI) * 25'(weff)
             + ((wm1 > 12'(dct_pkg::WIN_HI)) ? 25'(dct_pkg::WIN_HI) : 25'(wm1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_write) begin
      i_q <= 25'(in_row_q) * 25'(weff) + 25'(in_col_q);
      j_q <= 25'(out_row_q) * 25'(weff) + 25'(out_col_q);
    end
  end

  // window sweep
  logic [12:0] rr_q, r1_q;
  logic [dct_pkg::COL_W-1:0] cc_q, c0_q, c1_q;
  logic [13:0] r_hi;
  logic [12:0] r0, r1;
  logic [12:0] c_hi;
  logic [dct_pkg::COL_W-1:0] c0, c1;
  logic        last;

  always_comb begin
    r0   = (out_row_q >= 13'(dct_pkg::WIN_LO)) ? out_row_q - 13'(dct_pkg::WIN_LO) : '0;
    r_hi = 14'(out_row_q) + 14'(dct_pkg::WIN_HI);
    r1   = (r_hi > 14'(heff - 13'd1)) ? heff - 13'd1 : r_hi[12:0];
    c0   = (out_col_q >= 12'(dct_pkg::WIN_LO))
         ? dct_pkg::COL_W'(out_col_q - 12'(dct_pkg::WIN_LO)) : '0;
    c_hi = 13'(out_col_q) + 13'(dct_pkg::WIN_HI);
    c1   = (c_hi > 13'(wm1)) ? dct_pkg::COL_W'(wm1) : dct_pkg::COL_W'(c_hi);
  end

  assign last = (rr_q == r1_q) && (cc_q == c1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_bounds) begin
      rr_q <= r0;
      r1_q <= r1;
      cc_q <= c0;
      c0_q <= c0;
      c1_q <= c1;
    end else if (cmd_i.rd_issue) begin
      if (cc_q == c1_q) begin
        cc_q <= c0_q;
        rr_q <= rr_q + 13'd1;
      end else begin
        cc_q <= cc_q + dct_pkg::COL_W'(1);
      end
    end
  end

  // line store
  logic [15:0]      rdata;
  logic [AddrW-1:0] waddr, raddr;

  assign waddr = {in_row_q[dct_pkg::LINE_W-1:0], in_col_q[dct_pkg::COL_W-1:0]};
  assign raddr = {rr_q[dct_pkg::LINE_W-1:0], cc_q};

  dct_ram #(
    .Width (16),
    .Depth (dct_pkg::MEM_DEPTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pix_write),
    .waddr_i (waddr),
    .wdata_i (pix_min),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic        rd_pend_q;
  logic [15:0] min_q;
  logic [31:0] hprod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.rd_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_bounds) begin
      min_q <= 16'hFFFF;
    end else if (rd_pend_q && rdata < min_q) begin
      min_q <= rdata;
    end
    if (cmd_i.mul) begin
      hprod_q <= 32'(hkf_q) * 32'(min_q);
    end
  end

  // output register
  logic out_valid_q;
  dct_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.pixel_value <= mode_q ? (17'sd4096 - $signed({1'b0, hprod_q[31:16]}))
                                  : $signed({1'b0, min_q});
      out_q.frame_end   <= fe_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_func    = in_data_i.func;
    sts_o.input_done = done_q;
    sts_o.emit_due   = (j_q + dly) <= i_q;
    sts_o.last_addr  = last;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

`ifndef SYNTHESIS
  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled result");
  a_read_data_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |=> rd_pend_q)
    else $error("read data flag lost");
  a_sweep_in_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_issue |-> (rr_q <= r1_q))
    else $error("window sweep ran past last row");
`endif

endmodule
`default_nettype wire

/* rtl/core/dark_channel_transmission.sv */
// Top level of the dark channel / transmission estimator.
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) takes one request per
//    accept: a pixel (func 0, three channel bytes, raster order) or a flush
//    tick (func 1) that drains one pending output after the frame's last pixel.
//  - Output channel (out_valid_o / out_stall_i / out_data_o) returns zero or
//    one result per request: the eroded dark value (mode 0) or the signed
//    Q4.12 transmission (mode 1), with frame_end on the frame's last output.
//  - Config port (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) is
//    always ready; write registers only while the block is idle.
//  - One request at a time. A pixel that releases no output passes through
//    the prepare, write and compare states before the next accept; one that
//    releases an output then sweeps the clipped window (up to 15 x 15 = 225
//    entries), reading the line store one entry per cycle through its single
//    read port, before the drain, multiply and output states.
//  - Results sit in an output register; a new request is accepted while a
//    result waits. If the receiver stalls, the block holds the next result
//    in its final state until the output register frees.
//  - Reset returns registers to their defaults and clears positions; the
//    line store is not cleared and needs no clearing pass.
`default_nettype none
module dark_channel_transmission (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire dct_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output dct_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i
);

  dct_pkg::cmd_t cmd;
  dct_pkg::sts_t sts;

  // registers accept writes in any cycle
  assign cfg_ready_o = 1'b1;

  dct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dct_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
